@@ design/dtes_pkg.sv @@
package dtes_pkg;

    // field widths
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int SECS_W   = 38;
    localparam int WDAY_W   = 3;

    // pipeline depth, stage 5 is the output register
    localparam int NUM_STAGES = 5;

    // month codes
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // calendar constants
    localparam int EPOCH_YEAR     = 1970;
    localparam int DAYS_PER_YEAR  = 365;
    localparam int SECS_PER_DAY   = 86400;
    localparam int SECS_PER_HOUR  = 3600;
    localparam int SECS_PER_MIN   = 60;
    // leap days counted up to and including 1969: 492 - 19 + 4
    localparam int LEAP_BIAS      = 477;
    // weekday formula keeps a 400 year shift to stay positive
    localparam int CENTURY_SHIFT  = 4;

    // reciprocal multipliers for constant division
    localparam int RECIP_100       = 5243;
    localparam int RECIP_100_SHIFT = 19;
    localparam int RECIP_7         = 9363;
    localparam int RECIP_7_SHIFT   = 16;

    // tables indexed directly by month code, unused codes read 0
    localparam logic [8:0] DAYS_BEFORE_MONTH [16] = '{
        9'd0,   9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd0,   9'd0,   9'd0
    };

    localparam logic [4:0] MONTH_LENGTH [16] = '{
        5'd0,  5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0,  5'd0,  5'd0
    };

    // floor(13*(mm+1)/5) + 5, mod 7, with jan/feb as months 13/14
    localparam logic [2:0] ZELLER_TERM [16] = '{
        3'd0, 3'd6, 3'd2, 3'd1, 3'd4, 3'd6, 3'd2, 3'd4,
        3'd0, 3'd3, 3'd5, 3'd1, 3'd3, 3'd0, 3'd0, 3'd0
    };

    // per stage load strobes shared by the datapath lanes
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } t_pipe_ctl;

endpackage

@@ design/dtes_if.sv @@
interface dtes_date_if;
    logic                          valid;
    logic                          ready;
    logic [dtes_pkg::YEAR_W-1:0]   year;
    logic [dtes_pkg::MONTH_W-1:0]  month;
    logic [dtes_pkg::DAY_W-1:0]    day;
    logic [dtes_pkg::HOUR_W-1:0]   hour;
    logic [dtes_pkg::MINUTE_W-1:0] minute;
    logic [dtes_pkg::SECOND_W-1:0] second;

    modport source (output valid, year, month, day, hour, minute, second, input ready);
    modport sink   (input valid, year, month, day, hour, minute, second, output ready);
endinterface

interface dtes_epoch_if;
    logic                        valid;
    logic                        ready;
    logic [dtes_pkg::SECS_W-1:0] epoch_seconds;
    logic                        date_valid;
    logic [dtes_pkg::WDAY_W-1:0] weekday;

    modport source (output valid, epoch_seconds, date_valid, weekday, input ready);
    modport sink   (input valid, epoch_seconds, date_valid, weekday, output ready);
endinterface

@@ design/date_time_to_epoch_seconds_core.sv @@
// civil date and time to unix epoch seconds, weekday and date check
// throughput: one beat per cycle while o_epoch.ready does not hold the output
// five register stages with a valid bit each
// backpressure: each stage advances when the one after it is empty or moving
// reset: synchronous active low i_rst_n clears all stage valid bits
module date_time_to_epoch_seconds_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dtes_date_if.sink    i_date,
    dtes_epoch_if.source o_epoch
);

    localparam int NS = dtes_pkg::NUM_STAGES;

    // ---------------------------------------------------------------
    // stage handshake: valid bits and per stage ready chain
    // ---------------------------------------------------------------
    logic [NS-1:0]       r_vld;
    logic [NS-1:0]       stg_rdy;
    dtes_pkg::t_pipe_ctl ctl;

    always_comb begin
        stg_rdy[NS-1] = !r_vld[NS-1] || o_epoch.ready;
        for (int i = NS - 2; i >= 0; i--) begin
            stg_rdy[i] = !r_vld[i] || stg_rdy[i+1];
        end
        ctl.load[0] = stg_rdy[0] && i_date.valid;
        for (int i = 1; i < NS; i++) begin
            ctl.load[i] = stg_rdy[i] && r_vld[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_rdy[0]) begin
                r_vld[0] <= i_date.valid;
            end
            for (int i = 1; i < NS; i++) begin
                if (stg_rdy[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    assign i_date.ready = stg_rdy[0];

    // ---------------------------------------------------------------
    // stage 1: year / 100 by reciprocal, time of day, month tables
    // ---------------------------------------------------------------
    logic [26:0] n_s1_prod;
    logic [16:0] n_s1_tod;

    logic [dtes_pkg::YEAR_W-1:0]  r_s1_year;
    logic [dtes_pkg::MONTH_W-1:0] r_s1_month;
    logic [dtes_pkg::DAY_W-1:0]   r_s1_day;
    logic [7:0]                   r_s1_cent;
    logic [16:0]                  r_s1_tod;
    logic [8:0]                   r_s1_dbm;
    logic [4:0]                   r_s1_mlen;
    logic                         r_s1_mok;

    // exact for all 14 bit years (error term stays below 1/100)
    assign n_s1_prod = 27'(i_date.year) * 27'(dtes_pkg::RECIP_100);

    // hour, minute and second are taken as they come, no range check
    assign n_s1_tod = 17'(i_date.hour) * 17'(dtes_pkg::SECS_PER_HOUR)
                    + 17'(i_date.minute) * 17'(dtes_pkg::SECS_PER_MIN)
                    + 17'(i_date.second);

    always_ff @(posedge i_clk) begin
        if (ctl.load[0]) begin
            r_s1_year  <= i_date.year;
            r_s1_month <= i_date.month;
            r_s1_day   <= i_date.day;
            r_s1_cent  <= n_s1_prod[dtes_pkg::RECIP_100_SHIFT +: 8];
            r_s1_tod   <= n_s1_tod;
            r_s1_dbm   <= dtes_pkg::DAYS_BEFORE_MONTH[i_date.month];
            r_s1_mlen  <= dtes_pkg::MONTH_LENGTH[i_date.month];
            r_s1_mok   <= i_date.month inside {[dtes_pkg::MONTH_JAN:dtes_pkg::MONTH_DEC]};
        end
    end

    // ---------------------------------------------------------------
    // stage 2: year remainder, leap rule, leap days before the year,
    // day range check
    // ---------------------------------------------------------------
    logic [13:0] rem_full;
    logic [6:0]  year_rem;
    logic        rem_zero;
    logic        n_s2_leap;
    logic [7:0]  cent_prev;
    logic [13:0] year_m1;
    logic [13:0] leaps_full;
    logic [4:0]  month_len;
    logic        n_s2_valid;

    logic [dtes_pkg::YEAR_W-1:0] r_s2_yoff;
    logic [11:0]                 r_s2_leaps;
    logic [8:0]                  r_s2_dbm;
    logic [dtes_pkg::DAY_W-1:0]  r_s2_day;
    logic                        r_s2_late;
    logic                        r_s2_use;
    logic [16:0]                 r_s2_tod;
    logic                        r_s2_valid;

    always_comb begin
        rem_full  = r_s1_year - 14'(r_s1_cent) * 14'd100;
        year_rem  = rem_full[6:0];
        rem_zero  = (year_rem == 7'd0);
        // divisible by 4, and not a century unless divisible by 400
        n_s2_leap = (r_s1_year[1:0] == 2'd0) && (!rem_zero || (r_s1_cent[1:0] == 2'd0));
        // (year - 1) / 100 from year / 100
        cent_prev = r_s1_cent - 8'(rem_zero);
        year_m1   = r_s1_year - 14'd1;
        // leap days in 1970 .. year - 1, only used for years from 1970 on
        leaps_full = (year_m1 >> 2) - 14'(cent_prev) + 14'(cent_prev >> 2)
                   - 14'(dtes_pkg::LEAP_BIAS);
        month_len  = r_s1_mlen + 5'(n_s2_leap && (r_s1_month == dtes_pkg::MONTH_FEB));
        n_s2_valid = r_s1_mok && (r_s1_day != '0) && (r_s1_day <= month_len);
    end

    always_ff @(posedge i_clk) begin
        if (ctl.load[1]) begin
            r_s2_yoff  <= r_s1_year - 14'(dtes_pkg::EPOCH_YEAR);
            r_s2_leaps <= leaps_full[11:0];
            r_s2_dbm   <= r_s1_dbm;
            r_s2_day   <= r_s1_day;
            r_s2_late  <= n_s2_leap && (r_s1_month > dtes_pkg::MONTH_FEB);
            // seconds only for a real month and a year at or after the epoch
            r_s2_use   <= r_s1_mok && (r_s1_year >= 14'(dtes_pkg::EPOCH_YEAR));
            r_s2_tod   <= r_s1_tod;
            r_s2_valid <= n_s2_valid;
        end
    end

    // weekday lane runs alongside stages 2 to 5
    dtes_wday u_wday (
        .i_clk      (i_clk),
        .i_ctl      (ctl),
        .i_century  (r_s1_cent),
        .i_year_rem (year_rem),
        .i_month    (r_s1_month),
        .i_day      (r_s1_day),
        .i_month_ok (r_s1_mok),
        .o_weekday  (o_epoch.weekday)
    );

    // ---------------------------------------------------------------
    // stage 3: day count since the epoch, kept mod 2^31 so that day 0
    // at the epoch start wraps the same way the 38 bit seconds do
    // ---------------------------------------------------------------
    logic [22:0] n_s3_ydays;
    logic [30:0] n_s3_days;

    logic [30:0] r_s3_days;
    logic        r_s3_use;
    logic [16:0] r_s3_tod;
    logic        r_s3_valid;

    assign n_s3_ydays = 23'(r_s2_yoff) * 23'(dtes_pkg::DAYS_PER_YEAR);
    assign n_s3_days  = 31'(n_s3_ydays) + 31'(r_s2_leaps) + 31'(r_s2_dbm)
                      + 31'(r_s2_day) + 31'(r_s2_late) - 31'd1;

    always_ff @(posedge i_clk) begin
        if (ctl.load[2]) begin
            r_s3_days  <= n_s3_days;
            r_s3_use   <= r_s2_use;
            r_s3_tod   <= r_s2_tod;
            r_s3_valid <= r_s2_valid;
        end
    end

    // ---------------------------------------------------------------
    // stage 4: days to seconds, 31 x 17 multiply
    // ---------------------------------------------------------------
    logic [47:0] n_s4_prod;

    logic [dtes_pkg::SECS_W-1:0] r_s4_dsecs;
    logic                        r_s4_use;
    logic [16:0]                 r_s4_tod;
    logic                        r_s4_valid;

    assign n_s4_prod = 48'(r_s3_days) * 48'(dtes_pkg::SECS_PER_DAY);

    always_ff @(posedge i_clk) begin
        if (ctl.load[3]) begin
            r_s4_dsecs <= n_s4_prod[dtes_pkg::SECS_W-1:0];
            r_s4_use   <= r_s3_use;
            r_s4_tod   <= r_s3_tod;
            r_s4_valid <= r_s3_valid;
        end
    end

    // ---------------------------------------------------------------
    // stage 5: output register, add time of day
    // ---------------------------------------------------------------
    logic [dtes_pkg::SECS_W-1:0] r_s5_secs;
    logic                        r_s5_valid;

    always_ff @(posedge i_clk) begin
        if (ctl.load[4]) begin
            r_s5_secs  <= r_s4_use ? r_s4_dsecs + dtes_pkg::SECS_W'(r_s4_tod) : '0;
            r_s5_valid <= r_s4_valid;
        end
    end

    assign o_epoch.valid         = r_vld[NS-1];
    assign o_epoch.epoch_seconds = r_s5_secs;
    assign o_epoch.date_valid    = r_s5_valid;

endmodule

@@ design/dtes_wday.sv @@
module dtes_wday (
    input  logic                         i_clk,
    input  dtes_pkg::t_pipe_ctl          i_ctl,
    input  logic [7:0]                   i_century,
    input  logic [6:0]                   i_year_rem,
    input  logic [dtes_pkg::MONTH_W-1:0] i_month,
    input  logic [dtes_pkg::DAY_W-1:0]   i_day,
    input  logic                         i_month_ok,
    output logic [dtes_pkg::WDAY_W-1:0]  o_weekday
);

    logic       early;
    logic       rem_zero;
    logic [7:0] n_s2_j;
    logic [6:0] n_s2_k;

    logic [7:0]                 r_s2_j;
    logic [6:0]                 r_s2_k;
    logic [2:0]                 r_s2_term;
    logic [dtes_pkg::DAY_W-1:0] r_s2_day;
    logic                       r_s2_mok;

    logic [10:0] n_s3_sum;
    logic [10:0] r_s3_sum;
    logic        r_s3_mok;

    logic [23:0] n_s4_prod;
    logic [10:0] r_s4_sum;
    logic [7:0]  r_s4_q7;
    logic        r_s4_mok;

    logic [10:0] n_s5_rem;
    logic [dtes_pkg::WDAY_W-1:0] r_s5_wday;

    // jan and feb count as months of the previous year
    always_comb begin
        early    = (i_month <= dtes_pkg::MONTH_FEB);
        rem_zero = (i_year_rem == 7'd0);
        n_s2_j   = i_century + 8'(dtes_pkg::CENTURY_SHIFT) - 8'(early && rem_zero);
        if (early && rem_zero) begin
            n_s2_k = 7'd99;
        end else if (early) begin
            n_s2_k = i_year_rem - 7'd1;
        end else begin
            n_s2_k = i_year_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[1]) begin
            r_s2_j    <= n_s2_j;
            r_s2_k    <= n_s2_k;
            r_s2_term <= dtes_pkg::ZELLER_TERM[i_month];
            r_s2_day  <= i_day;
            r_s2_mok  <= i_month_ok;
        end
    end

    assign n_s3_sum = 11'(r_s2_day) + 11'(r_s2_term) + 11'(r_s2_k) + 11'(r_s2_k >> 2)
                    + 11'(r_s2_j >> 2) + 11'(r_s2_j) * 11'd5;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[2]) begin
            r_s3_sum <= n_s3_sum;
            r_s3_mok <= r_s2_mok;
        end
    end

    // sum / 7 by reciprocal, exact for sums below 13107
    assign n_s4_prod = 24'(r_s3_sum) * 24'(dtes_pkg::RECIP_7);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[3]) begin
            r_s4_sum <= r_s3_sum;
            r_s4_q7  <= n_s4_prod[dtes_pkg::RECIP_7_SHIFT +: 8];
            r_s4_mok <= r_s3_mok;
        end
    end

    assign n_s5_rem = r_s4_sum - 11'(r_s4_q7) * 11'd7;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[4]) begin
            r_s5_wday <= r_s4_mok ? n_s5_rem[dtes_pkg::WDAY_W-1:0] : '0;
        end
    end

    assign o_weekday = r_s5_wday;

endmodule

@@ design/dtes_chk.sv @@
module dtes_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [dtes_pkg::SECS_W-1:0] i_epoch_seconds,
    input logic                        i_date_valid,
    input logic [dtes_pkg::WDAY_W-1:0] i_weekday
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output beat present right after reset");

    // a stalled output beat holds its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_epoch_seconds)
            && $stable(i_date_valid) && $stable(i_weekday))
        else $error("stalled output beat changed");

    // with no output pending every stage can move, so input must be open
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked while output is empty");

    // weekday is a remainder mod 7
    a_wday_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_weekday <= 3'd6)
        else $error("weekday out of range");

endmodule

bind date_time_to_epoch_seconds_core dtes_chk u_dtes_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_date.ready),
    .i_out_valid     (o_epoch.valid),
    .i_out_ready     (o_epoch.ready),
    .i_epoch_seconds (o_epoch.epoch_seconds),
    .i_date_valid    (o_epoch.date_valid),
    .i_weekday       (o_epoch.weekday)
);
